// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under the block reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under the block reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/frm_pkg.sv
package frm_pkg;

    typedef struct packed {
        logic [31:0] now_us;
        logic [14:0] pulse_count;
        logic        read_ok;
    } t_req;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] flow_lpm_q16;
        logic [14:0] pulses;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_FLT,
        ST_F5,
        ST_DONE
    } t_state;

    localparam logic CFG_PPL      = 1'b0;
    localparam logic CFG_INTERVAL = 1'b1;

    localparam logic [15:0] PPL_RESET      = 16'd45000;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000000;

    // microseconds per minute times 100
    localparam logic [32:0] US_PER_MIN_X100 = 33'd6000000000;

    localparam logic [4:0] MUL_LAST = 5'd15;
    localparam logic [4:0] DIV_LAST = 5'd31;
    localparam logic [4:0] F5_LAST  = 5'd17;

    // one restoring step of a divide by five: {quotient bit, remainder}
    function automatic logic [3:0] f5_step(input logic [2:0] rem, input logic din);
        logic [3:0] t;
        logic [3:0] d;
        t = {rem, din};
        d = t - 4'd5;
        if (t >= 4'd5) begin
            f5_step = {1'b1, d[2:0]};
        end else begin
            f5_step = {1'b0, t[2:0]};
        end
    endfunction

endpackage

// File: rtl/flow_rate_meter_filtered_top.sv
// no measurement due, or a failed read: idle goes straight to the output load
// a new measurement: multiply, check, divide (one quotient bit per cycle), filter setup,
//   divide-by-five and output load; a zero count or an overflow skips the divide, and the
//   first result or a zero count skips the divide-by-five; requests are taken only in idle
// reset: synchronous active low, clears state, flow history and output valid,
//   and loads the default pulses-per-litre and interval registers
`include "assert_macros.svh"

module flow_rate_meter_filtered_top import frm_pkg::*; #(
    parameter int FLOW_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int SHIFT = 32 - FLOW_FRAC_BITS;

    t_state      r_state, n_state;
    logic [15:0] r_ppl, n_ppl;
    logic [31:0] r_interval, n_interval;
    logic [31:0] r_last_time, n_last_time;
    logic [14:0] r_last_pulses, n_last_pulses;
    logic [31:0] r_filt, n_filt;
    logic        r_has, n_has;
    logic        r_res_valid, n_res_valid;
    t_res        r_res, n_res;
    logic        r_res_ok, n_res_ok;
    logic [4:0]  r_step, n_step;
    logic [31:0] r_elapsed, n_elapsed;
    logic [15:0] r_ppl_sh, n_ppl_sh;
    logic [15:0] r_cnt_sh, n_cnt_sh;
    logic [47:0] r_num, n_num;
    logic [47:0] r_den, n_den;
    logic [47:0] r_rem, n_rem;
    logic [35:0] r_shift, n_shift;

    logic        req_acc;
    logic [31:0] elapsed;
    logic        due;
    logic        ovf;
    logic [48:0] div_t;
    logic [48:0] div_d;
    logic        div_ge;
    logic [3:0]  f5_a;
    logic [3:0]  f5_b;
    logic [31:0] nf;

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign elapsed = i_req.now_us - r_last_time;
    assign due     = (elapsed >= r_interval);
    assign ovf     = ({24'd0, r_num} >= ({24'd0, r_den} << SHIFT));
    assign div_t   = {r_rem, r_shift[31]};
    assign div_d   = div_t - {1'b0, r_den};
    assign div_ge  = (div_t >= {1'b0, r_den});
    assign f5_a    = f5_step(r_rem[2:0], r_shift[35]);
    assign f5_b    = f5_step(f5_a[2:0], r_shift[34]);
    assign nf      = r_shift[31:0];

    always_comb begin
        n_state       = r_state;
        n_ppl         = r_ppl;
        n_interval    = r_interval;
        n_last_time   = r_last_time;
        n_last_pulses = r_last_pulses;
        n_filt        = r_filt;
        n_has         = r_has;
        n_res_valid   = r_res_valid;
        n_res         = r_res;
        n_res_ok      = r_res_ok;
        n_step        = r_step;
        n_elapsed     = r_elapsed;
        n_ppl_sh      = r_ppl_sh;
        n_cnt_sh      = r_cnt_sh;
        n_num         = r_num;
        n_den         = r_den;
        n_rem         = r_rem;
        n_shift       = r_shift;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PPL:      n_ppl      = i_cfg_data[15:0];
                CFG_INTERVAL: n_interval = i_cfg_data;
                default:      n_ppl      = r_ppl;
            endcase
        end

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    if (due && i_req.read_ok) begin
                        n_last_time   = i_req.now_us;
                        n_last_pulses = i_req.pulse_count;
                        n_elapsed     = elapsed;
                        n_ppl_sh      = r_ppl;
                        n_cnt_sh      = {1'b0, i_req.pulse_count};
                        n_num         = '0;
                        n_den         = '0;
                        n_step        = MUL_LAST;
                        n_res_ok      = 1'b1;
                        n_state       = ST_MUL;
                    end else begin
                        n_res_ok = !due;
                        n_state  = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                // msb-first shift and add, one multiplier bit per cycle
                n_num    = {r_num[46:0], 1'b0}
                         + (r_cnt_sh[15] ? 48'(US_PER_MIN_X100) : 48'd0);
                n_den    = {r_den[46:0], 1'b0}
                         + (r_ppl_sh[15] ? 48'(r_elapsed) : 48'd0);
                n_cnt_sh = {r_cnt_sh[14:0], 1'b0};
                n_ppl_sh = {r_ppl_sh[14:0], 1'b0};
                n_step   = r_step - 5'd1;
                if (r_step == 5'd0) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (r_last_pulses == 15'd0) begin
                    n_shift = '0;
                    n_state = ST_FLT;
                end else if (ovf) begin
                    n_shift = {4'd0, 32'hFFFF_FFFF};
                    n_state = ST_FLT;
                end else begin
                    n_rem   = r_num >> SHIFT;
                    n_shift = {4'd0, 32'(r_num << FLOW_FRAC_BITS)};
                    n_step  = DIV_LAST;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem   = div_ge ? div_d[47:0] : div_t[47:0];
                n_shift = {r_shift[34:0], div_ge};
                n_step  = r_step - 5'd1;
                if (r_step == 5'd0) begin
                    n_state = ST_FLT;
                end
            end
            ST_FLT: begin
                if (!r_has) begin
                    n_filt  = nf;
                    n_has   = 1'b1;
                    n_state = ST_DONE;
                end else if (r_last_pulses == 15'd0) begin
                    n_filt  = '0;
                    n_state = ST_DONE;
                end else begin
                    n_shift = 36'(r_filt) + {2'b00, nf, 2'b00} + 36'd2;
                    n_rem   = '0;
                    n_step  = F5_LAST;
                    n_state = ST_F5;
                end
            end
            ST_F5: begin
                // two quotient bits per cycle
                n_rem   = {45'd0, f5_b[2:0]};
                n_shift = {r_shift[33:0], f5_a[3], f5_b[3]};
                n_step  = r_step - 5'd1;
                if (r_step == 5'd0) begin
                    n_filt  = n_shift[31:0];
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res_valid        = 1'b1;
                    n_res.valid_res    = r_res_ok;
                    n_res.flow_lpm_q16 = r_res_ok ? r_filt : 32'd0;
                    n_res.pulses       = r_res_ok ? r_last_pulses : 15'd0;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ppl         <= PPL_RESET;
            r_interval    <= INTERVAL_RESET;
            r_last_time   <= '0;
            r_last_pulses <= '0;
            r_filt        <= '0;
            r_has         <= 1'b0;
            r_res_valid   <= 1'b0;
            r_step        <= '0;
        end else begin
            r_state       <= n_state;
            r_ppl         <= n_ppl;
            r_interval    <= n_interval;
            r_last_time   <= n_last_time;
            r_last_pulses <= n_last_pulses;
            r_filt        <= n_filt;
            r_has         <= n_has;
            r_res_valid   <= n_res_valid;
            r_step        <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res     <= n_res;
        r_res_ok  <= n_res_ok;
        r_elapsed <= n_elapsed;
        r_ppl_sh  <= n_ppl_sh;
        r_cnt_sh  <= n_cnt_sh;
        r_num     <= n_num;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_shift   <= n_shift;
    end

    `ASSERT_NEXT(a_one_request, i_clk, i_rst_n, req_acc, !o_req_ready)
    `ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_res_valid && !o_res.valid_res,
        (o_res.flow_lpm_q16 == 32'd0) && (o_res.pulses == 15'd0))
    `ASSERT_IMPL(a_div_rem, i_clk, i_rst_n, r_state == ST_DIV, r_rem < r_den)
    `ASSERT_IMPL(a_f5_rem, i_clk, i_rst_n, r_state == ST_F5, r_rem[2:0] < 3'd5)

endmodule
